// File: hdl/gauss3_pkg.sv
// Shared constants for the 3x3 binomial smoothing core.
// Holds register indexes, field widths and parameter defaults; no dependencies.
package gauss3_pkg;

   localparam int DEF_MAX_LINE   = 256;
   localparam int DEF_PIXEL_BITS = 8;

   localparam int ROW_BITS      = 12;
   localparam int COL_OUT_BITS  = 8;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int WIDTH_BITS    = 9;
   localparam int BORDER_BITS   = 8;

   localparam logic [CSR_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_BORDER_VALUE = 2'd2;

   localparam logic [WIDTH_BITS-1:0]  RST_IMAGE_WIDTH  = 9'd159;
   localparam logic [ROW_BITS-1:0]    RST_IMAGE_HEIGHT = 12'd199;
   localparam logic [BORDER_BITS-1:0] RST_BORDER_VALUE = 8'd4;

   localparam int MIN_DIM = 3;

endpackage

// File: hdl/gaussian_3x3_smoothing_filter_core.sv
// Top level of the 3x3 binomial smoothing core: line memory, window and result queue.
// Depends on gauss3_pkg for register indexes, widths and defaults.
//
// Channel  Dir  Handshake             Payload
// req      in   req_tvalid/tready     tdata: pixel_in
// rsp      out  rsp_tvalid/tready     tdata: pixel_out, out_row, out_col; tlast: frame_last
// csr      in   csr_valid/csr_ready   csr_index, csr_data
//
// A pixel enters every cycle unless the result queue holds it back; the line memory
// read is registered and the window sum is formed as the pixel leaves that stage.
// Pixels that give one result sustain one transaction per cycle while rsp_tready is high;
// the last column and row give two to four, drained one per ready cycle while input stalls.
// Reset is synchronous and clears the counters, the window and the queue, not the memory.
module gaussian_3x3_smoothing_filter_core
   import gauss3_pkg::*;
#(
   parameter int MAX_LINE   = DEF_MAX_LINE,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS,
   localparam int IN_BITS   = ((PIXEL_BITS + 7) / 8) * 8,
   localparam int OUT_BITS  = ((PIXEL_BITS + ROW_BITS + COL_OUT_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [IN_BITS-1:0]       req_tdata,   // pixel_in
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [OUT_BITS-1:0]      rsp_tdata,   // pixel_out, out_row, out_col
   output logic                     rsp_tlast,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int COL_BITS = $clog2(MAX_LINE);
   localparam int WB0      = $clog2(MAX_LINE + 1);
   localparam int WB       = (WB0 > WIDTH_BITS) ? WB0 : WIDTH_BITS;
   localparam int SUM_BITS = PIXEL_BITS + 4;
   localparam int PAD_BITS = OUT_BITS - PIXEL_BITS - ROW_BITS - COL_OUT_BITS;

   typedef struct packed {
      logic [PIXEL_BITS-1:0]   pix;
      logic [ROW_BITS-1:0]     row;
      logic [COL_OUT_BITS-1:0] col;
      logic                    last;
   } rsp_item_type;

   logic [WIDTH_BITS-1:0]  image_width_ff;
   logic [ROW_BITS-1:0]    image_height_ff;
   logic [BORDER_BITS-1:0] border_value_ff;

   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [COL_BITS-1:0] col_ff, col_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic [PIXEL_BITS-1:0] s1_pix_ff;
   logic [ROW_BITS-1:0]   s1_row_ff;
   logic [COL_BITS-1:0]   s1_col_ff;
   logic                  s1_emit_ff, s1_inner_ff, s1_last_row_ff, s1_last_col_ff;

   logic [2*PIXEL_BITS-1:0] line_mem [MAX_LINE];
   logic [2*PIXEL_BITS-1:0] rd_ff;

   logic [PIXEL_BITS-1:0] win_ff [2][3];

   rsp_item_type q_ff [4];
   logic [2:0]   cnt_ff, cnt_in;

   logic [WB-1:0]         w_raw, w_eff;
   logic [ROW_BITS-1:0]   h_eff;
   logic [PIXEL_BITS-1:0] bord;
   logic [ROW_BITS:0]     row_p1, r_pre, nrow;
   logic [ROW_BITS-1:0]   cur_r;
   logic [COL_BITS-1:0]   cur_c;
   logic [WB-1:0]         cur_c_ext, ncol;
   logic                  accept, fire, take, gen_free;
   logic [PIXEL_BITS-1:0] top, mid;
   logic [SUM_BITS-1:0]   sum;
   logic [PIXEL_BITS-1:0] val;
   rsp_item_type          it_a, it_b, it_c, it_d;
   logic [2:0]            n_res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= RST_IMAGE_WIDTH;
         image_height_ff <= RST_IMAGE_HEIGHT;
         border_value_ff <= RST_BORDER_VALUE;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_data[WIDTH_BITS-1:0];
            REG_IMAGE_HEIGHT: image_height_ff <= csr_data[ROW_BITS-1:0];
            REG_BORDER_VALUE: border_value_ff <= csr_data[BORDER_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w_raw = WB'(image_width_ff);
      if (w_raw < WB'(MIN_DIM)) begin
         w_eff = WB'(MIN_DIM);
      end else if (w_raw > WB'(MAX_LINE)) begin
         w_eff = WB'(MAX_LINE);
      end else begin
         w_eff = w_raw;
      end
      h_eff = (image_height_ff < ROW_BITS'(MIN_DIM)) ? ROW_BITS'(MIN_DIM) : image_height_ff;
      bord  = PIXEL_BITS'(border_value_ff);
   end

   // Position of the incoming pixel, with the wrap taken first in case the geometry shrank.
   always_comb begin
      row_p1 = {1'b0, row_ff} + 1'b1;
      if (WB'(col_ff) >= w_eff) begin
         cur_c = '0;
         r_pre = row_p1;
      end else begin
         cur_c = col_ff;
         r_pre = {1'b0, row_ff};
      end
      cur_r     = (r_pre >= {1'b0, h_eff}) ? '0 : r_pre[ROW_BITS-1:0];
      cur_c_ext = WB'(cur_c);
      ncol      = cur_c_ext + 1'b1;
      nrow      = {1'b0, cur_r} + 1'b1;
   end

   assign take       = rsp_tvalid && rsp_tready;
   assign gen_free   = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && rsp_tready);
   assign fire       = s1_valid_ff && gen_free;
   assign req_tready = !s1_valid_ff || fire;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      s1_valid_in = s1_valid_ff;
      if (fire) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         if (ncol >= w_eff) begin
            col_in = '0;
            row_in = (nrow >= {1'b0, h_eff}) ? '0 : nrow[ROW_BITS-1:0];
         end else begin
            col_in = ncol[COL_BITS-1:0];
            row_in = cur_r;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff      <= req_tdata[PIXEL_BITS-1:0];
         s1_row_ff      <= cur_r;
         s1_col_ff      <= cur_c;
         s1_emit_ff     <= (cur_r != '0) && (cur_c != '0);
         s1_inner_ff    <= (cur_r >= ROW_BITS'(2)) && (cur_c >= COL_BITS'(2));
         s1_last_row_ff <= (cur_r == h_eff - 1'b1);
         s1_last_col_ff <= (cur_c_ext == w_eff - 1'b1);
      end
   end

   // Entry c holds the two previous rows at column c; consecutive pixels never share a column,
   // so the write of one pixel and the read of the next never meet.
   always_ff @(posedge clock) begin
      if (fire) begin
         line_mem[s1_col_ff] <= {s1_pix_ff, mid};
      end
      if (accept) begin
         rd_ff <= line_mem[cur_c];
      end
   end

   assign top = rd_ff[PIXEL_BITS-1:0];
   assign mid = rd_ff[2*PIXEL_BITS-1:PIXEL_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (fire) begin
         win_ff[0]    <= win_ff[1];
         win_ff[1][0] <= top;
         win_ff[1][1] <= mid;
         win_ff[1][2] <= s1_pix_ff;
      end
   end

   always_comb begin
      sum = SUM_BITS'(win_ff[0][0]) + (SUM_BITS'(win_ff[0][1]) << 1) + SUM_BITS'(win_ff[0][2])
          + (SUM_BITS'(win_ff[1][0]) << 1) + (SUM_BITS'(win_ff[1][1]) << 2)
          + (SUM_BITS'(win_ff[1][2]) << 1)
          + SUM_BITS'(top) + (SUM_BITS'(mid) << 1) + SUM_BITS'(s1_pix_ff) + SUM_BITS'(7);
      val = s1_inner_ff ? sum[SUM_BITS-1:4] : bord;

      it_a.pix  = val;
      it_a.row  = s1_row_ff - 1'b1;
      it_a.col  = COL_OUT_BITS'(s1_col_ff - 1'b1);
      it_a.last = 1'b0;
      it_b.pix  = bord;
      it_b.row  = s1_row_ff;
      it_b.col  = it_a.col;
      it_b.last = 1'b0;
      it_c.pix  = bord;
      it_c.row  = it_a.row;
      it_c.col  = COL_OUT_BITS'(s1_col_ff);
      it_c.last = 1'b0;
      it_d.pix  = bord;
      it_d.row  = s1_row_ff;
      it_d.col  = it_c.col;
      it_d.last = 1'b1;

      if (!s1_emit_ff) begin
         n_res = 3'd0;
      end else if (s1_last_row_ff && s1_last_col_ff) begin
         n_res = 3'd4;
      end else if (s1_last_row_ff || s1_last_col_ff) begin
         n_res = 3'd2;
      end else begin
         n_res = 3'd1;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (fire) begin
         cnt_in = n_res;
      end else if (take) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         q_ff[0] <= it_a;
         q_ff[1] <= s1_last_row_ff ? it_b : it_c;
         q_ff[2] <= it_c;
         q_ff[3] <= it_d;
      end else if (take) begin
         q_ff[0] <= q_ff[1];
         q_ff[1] <= q_ff[2];
         q_ff[2] <= q_ff[3];
      end
   end

   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign rsp_tlast  = q_ff[0].last;

   generate
      if (PAD_BITS > 0) begin : g_pad
         assign rsp_tdata = {{PAD_BITS{1'b0}}, q_ff[0].col, q_ff[0].row, q_ff[0].pix};
      end else begin : g_nopad
         assign rsp_tdata = {q_ff[0].col, q_ff[0].row, q_ff[0].pix};
      end
   endgenerate

endmodule

// File: sim/gaussian_3x3_smoothing_filter_core_test.sv
// Self-checking testbench for the 3x3 binomial smoothing core: streams directed and random
// frames via the pixel channel under varied idling and stalls; a local predictor checks each.
// Depends on gauss3_pkg and gaussian_3x3_smoothing_filter_core.
module gaussian_3x3_smoothing_filter_core_test
   import gauss3_pkg::*;
();

   localparam int PIX_W       = DEF_PIXEL_BITS;
   localparam int REQ_BITS    = ((PIX_W + 7) / 8) * 8;
   localparam int RSP_BITS    = ((PIX_W + ROW_BITS + COL_OUT_BITS + 7) / 8) * 8;
   localparam int LINE_LEN    = DEF_MAX_LINE;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 16;
   localparam logic [CSR_IDX_BITS-1:0] REG_UNUSED = 2'd3;

   typedef struct {
      logic [PIX_W-1:0]        value;
      logic [ROW_BITS-1:0]     row;
      logic [COL_OUT_BITS-1:0] col;
      logic                    last;
   } pixel_result_type;

   class blur_checker_type;
      logic [WIDTH_BITS-1:0]  width_reg;
      logic [ROW_BITS-1:0]    height_reg;
      logic [BORDER_BITS-1:0] border_reg;
      logic [PIX_W-1:0]       upper_line[LINE_LEN];
      logic [PIX_W-1:0]       lower_line[LINE_LEN];
      logic [PIX_W-1:0]       win[9];
      int                     row_pos;
      int                     col_pos;
      int                     mismatches;
      pixel_result_type       due_outputs[$];

      function new();
         width_reg  = RST_IMAGE_WIDTH;
         height_reg = RST_IMAGE_HEIGHT;
         border_reg = RST_BORDER_VALUE;
         foreach (upper_line[i]) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
         end
         foreach (win[i]) win[i] = '0;
         row_pos    = 0;
         col_pos    = 0;
         mismatches = 0;
      endfunction

      function int eff_width();
         int w;
         w = int'(width_reg);
         if (w < MIN_DIM) w = MIN_DIM;
         if (w > LINE_LEN) w = LINE_LEN;
         return w;
      endfunction

      function int eff_height();
         int h;
         h = int'(height_reg);
         if (h < MIN_DIM) h = MIN_DIM;
         if (h > 4095) h = 4095;
         return h;
      endfunction

      function void set_register(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            REG_IMAGE_WIDTH: begin
               width_reg = data[WIDTH_BITS-1:0];
            end
            REG_IMAGE_HEIGHT: begin
               height_reg = data[ROW_BITS-1:0];
            end
            REG_BORDER_VALUE: begin
               border_reg = data[BORDER_BITS-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function int pixels_to_frame_end();
         int w, h, r, c;
         w = eff_width();
         h = eff_height();
         r = row_pos;
         c = col_pos;
         if (c >= w) begin
            c = 0;
            r++;
         end
         if (r >= h) r = 0;
         return (r == 0 && c == 0) ? 0 : w * h - (r * w + c);
      endfunction

      function void queue_result(int value, int row, int col, bit last);
         pixel_result_type res;
         res.value = value[PIX_W-1:0];
         res.row   = row[ROW_BITS-1:0];
         res.col   = col[COL_OUT_BITS-1:0];
         res.last  = last;
         due_outputs.push_back(res);
      endfunction

      function void absorb_pixel(logic [PIX_W-1:0] pixel);
         int w, h, r, c, s, value, border;
         w = eff_width();
         h = eff_height();
         border = int'(border_reg[PIX_W-1:0]);
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos >= h) row_pos = 0;
         r = row_pos;
         c = col_pos;
         for (int i = 0; i < 6; i++) win[i] = win[i + 3];
         win[6] = upper_line[c];
         win[7] = lower_line[c];
         win[8] = pixel;
         upper_line[c] = lower_line[c];
         lower_line[c] = pixel;
         if (r >= 1 && c >= 1) begin
            if (r >= 2 && c >= 2) begin
               s = int'(win[0]) + 2 * int'(win[1]) + int'(win[2])
                 + 2 * int'(win[3]) + 4 * int'(win[4]) + 2 * int'(win[5])
                 + int'(win[6]) + 2 * int'(win[7]) + int'(win[8]) + 7;
               value = s >> 4;
            end else begin
               value = border;
            end
            queue_result(value, r - 1, c - 1, 1'b0);
            if (r == h - 1) queue_result(border, r, c - 1, 1'b0);
            if (c == w - 1) begin
               queue_result(border, r - 1, w - 1, 1'b0);
               if (r == h - 1) queue_result(border, r, w - 1, 1'b1);
            end
         end
         col_pos++;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
         end
      endfunction

      task report(string what, int got, int want);
         if (mismatches < 40)
            $display("mismatch: %s got %0d expected %0d", what, got, want);
         mismatches++;
      endtask

      task check_output(logic [PIX_W-1:0] value, logic [ROW_BITS-1:0] row,
                        logic [COL_OUT_BITS-1:0] col, logic last);
         pixel_result_type want;
         if (due_outputs.size() == 0) begin
            report("output pixel with none pending, value", int'(value), -1);
         end else begin
            want = due_outputs.pop_front();
            if (value !== want.value) report("pixel_out", int'(value), int'(want.value));
            if (row !== want.row) report("out_row", int'(row), int'(want.row));
            if (col !== want.col) report("out_col", int'(col), int'(want.col));
            if (last !== want.last) report("frame_last", int'(last), int'(want.last));
         end
      endtask
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_BITS-1:0]      req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_BITS-1:0]      rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   int               idle_pct;
   int               stall_pct;
   int               quiet_cycles;
   bit               moved;
   blur_checker_type sb = new();

   gaussian_3x3_smoothing_filter_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            moved = 1'b0;
            if (req_tvalid && req_tready) begin
               sb.absorb_pixel(req_tdata[PIX_W-1:0]);
               moved = 1'b1;
            end
            if (rsp_tvalid && rsp_tready) begin
               sb.check_output(rsp_tdata[PIX_W-1:0], rsp_tdata[PIX_W +: ROW_BITS],
                               rsp_tdata[PIX_W + ROW_BITS +: COL_OUT_BITS], rsp_tlast);
               moved = 1'b1;
            end
            if (csr_valid && csr_ready) begin
               sb.set_register(csr_index, csr_data);
               moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("gaussian_3x3_smoothing_filter_core_test failed");
               $finish;
            end
         end
      end
   end

   function logic [PIX_W-1:0] random_pixel();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom_range(255));
      endcase
   endfunction

   task write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task stream_pixels(int n, bit directed);
      logic [PIX_W-1:0] v;
      for (int i = 0; i < n; i++) begin
         if (directed)
            v = (i < 9) ? 8'hFF : (i < 18) ? 8'h00 : ((i % 2) ? 8'hFF : 8'h00);
         else
            v = random_pixel();
         @(negedge clock);
         while ($urandom_range(99) < idle_pct) begin
            req_tvalid = 1'b0;
            @(negedge clock);
         end
         req_tvalid = 1'b1;
         req_tdata  = v;
         do @(posedge clock); while (!req_tready);
      end
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task wait_drained();
      @(posedge clock);
      while (sb.due_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task run_geometry(logic [CSR_DATA_BITS-1:0] w_data, logic [CSR_DATA_BITS-1:0] h_data,
                     logic [CSR_DATA_BITS-1:0] b_data, int count);
      wait_drained();
      write_reg(REG_IMAGE_WIDTH, w_data);
      write_reg(REG_IMAGE_HEIGHT, h_data);
      write_reg(REG_BORDER_VALUE, b_data);
      stream_pixels(count, 1'b0);
      stream_pixels(sb.pixels_to_frame_end(), 1'b0);
   endtask

   initial begin
      logic [CSR_DATA_BITS-1:0] w_data, h_data;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      idle_pct   = 0;
      stall_pct  = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Three 3x3 frames: all white, all black, then a checkerboard.
      write_reg(REG_IMAGE_WIDTH, 16'hFE03);
      write_reg(REG_IMAGE_HEIGHT, 16'hF003);
      write_reg(REG_BORDER_VALUE, 16'h5AA5);
      write_reg(REG_UNUSED, 16'hFFFF);
      stream_pixels(27, 1'b1);

      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 81; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 81; end
            default: begin idle_pct = 10; stall_pct = 10; end
         endcase
         repeat (3) begin
            w_data = {7'($urandom), ($urandom_range(9) == 0) ? 9'($urandom_range(2))
                                                            : 9'(3 + $urandom_range(9))};
            h_data = {4'($urandom), ($urandom_range(9) == 0) ? 12'($urandom_range(2))
                                                            : 12'(3 + $urandom_range(3))};
            run_geometry(w_data, h_data, 16'($urandom), 10 + $urandom_range(20));
         end
         if (mode == 0)
            run_geometry(16'h01FF, 16'h0003, 16'h00FF, 0);
         if (mode == 3) begin
            // A tall frame cut short by lowering the height part way through.
            wait_drained();
            write_reg(REG_IMAGE_WIDTH, 16'h0003);
            write_reg(REG_IMAGE_HEIGHT, 16'h0FFF);
            write_reg(REG_BORDER_VALUE, 16'hFF00);
            stream_pixels(40, 1'b0);
            wait_drained();
            write_reg(REG_IMAGE_HEIGHT, 16'h0003);
            stream_pixels(sb.pixels_to_frame_end(), 1'b0);
         end
      end

      wait_drained();
      if (sb.mismatches == 0 && sb.due_outputs.size() == 0)
         $display("gaussian_3x3_smoothing_filter_core_test passed");
      else
         $display("gaussian_3x3_smoothing_filter_core_test failed");
      $finish;
   end

endmodule
